>>> hw/rtl/rotation_matrix_to_euler_angles_macros.svh
// ----------------------------------------------------------------------------
// Euler angle block assertion macros
// Clocked assertion shorthands used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_MACROS_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_MACROS_SVH

// checked only while out of reset
`define RET_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define RET_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> hw/rtl/ret_pkg.sv
// ----------------------------------------------------------------------------
// Euler angle package
// Widths, constants and the CORDIC angle table in degrees (Q22).
// ----------------------------------------------------------------------------
package ret_pkg;

    localparam int MAT_W     = 32;
    localparam int ANG_OUT_W = 31;
    localparam int THR_W     = 31;
    localparam int OPD_W     = 33;   // CORDIC operand at entry
    localparam int CRD_W     = 36;   // CORDIC x/y datapath
    localparam int ANG_W     = 33;   // angle accumulator
    localparam int SQ_LAT    = 34;   // square, sum, 32 root digits
    localparam int CORDIC_STEPS_DEF = 24;
    localparam logic [THR_W-1:0] THRESH_RESET = 31'd1074;
    localparam logic signed [ANG_W-1:0] HALF_TURN = 33'sd754974720;

    function automatic logic signed [ANG_W-1:0] atan_deg(input int idx);
        logic signed [ANG_W-1:0] v;
        begin
            unique case (idx)
                0:  v = 33'sd188743680;
                1:  v = 33'sd111421900;
                2:  v = 33'sd58872272;
                3:  v = 33'sd29884485;
                4:  v = 33'sd15000234;
                5:  v = 33'sd7507429;
                6:  v = 33'sd3754631;
                7:  v = 33'sd1877430;
                8:  v = 33'sd938729;
                9:  v = 33'sd469366;
                10: v = 33'sd234683;
                11: v = 33'sd117342;
                12: v = 33'sd58671;
                13: v = 33'sd29335;
                14: v = 33'sd14668;
                15: v = 33'sd7334;
                16: v = 33'sd3667;
                17: v = 33'sd1833;
                18: v = 33'sd917;
                19: v = 33'sd458;
                20: v = 33'sd229;
                21: v = 33'sd115;
                22: v = 33'sd57;
                23: v = 33'sd29;
                24: v = 33'sd14;
                25: v = 33'sd7;
                26: v = 33'sd4;
                27: v = 33'sd2;
                28: v = 33'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    typedef struct packed {
        logic signed [MAT_W-1:0] m00;
        logic signed [MAT_W-1:0] m10;
        logic signed [MAT_W-1:0] m20;
        logic signed [MAT_W-1:0] m21;
        logic signed [MAT_W-1:0] m22;
        logic signed [MAT_W-1:0] m11;
        logic signed [MAT_W-1:0] m12;
    } mat_t;

endpackage

>>> hw/rtl/ret_isqrt.sv
// ----------------------------------------------------------------------------
// Euler angle sy unit
// sy = floor(sqrt(m00^2 + m10^2)), squares then one root digit per stage.
// ----------------------------------------------------------------------------
module ret_isqrt
    import ret_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [MAT_W-1:0] m00,
    input  logic signed [MAT_W-1:0] m10,
    output logic        [31:0]      sy
);

    logic [31:0] a_abs, b_abs;
    logic [63:0] sq_a_reg, sq_b_reg, sum_reg;
    logic [63:0] rad_reg  [0:32];
    logic [33:0] rem_reg  [0:32];
    logic [31:0] root_reg [0:32];

    assign a_abs = m00[31] ? 32'(-m00) : 32'(m00);
    assign b_abs = m10[31] ? 32'(-m10) : 32'(m10);

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_a_reg <= 64'(a_abs) * 64'(a_abs);
            sq_b_reg <= 64'(b_abs) * 64'(b_abs);
            sum_reg  <= sq_a_reg + sq_b_reg;
        end
    end

    assign rad_reg[0]  = sum_reg;
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;

    for (genvar k = 0; k < 32; k++) begin : g_dig
        logic [35:0] rem_t, trial;
        assign rem_t = {rem_reg[k], rad_reg[k][63:62]};
        assign trial = {2'b00, root_reg[k], 2'b01};
        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k+1] <= {rad_reg[k][61:0], 2'b00};
                if (rem_t >= trial) begin
                    rem_reg[k+1]  <= 34'(rem_t - trial);
                    root_reg[k+1] <= {root_reg[k][30:0], 1'b1};
                end else begin
                    rem_reg[k+1]  <= rem_t[33:0];
                    root_reg[k+1] <= {root_reg[k][30:0], 1'b0};
                end
            end
        end
    end

    assign sy = root_reg[32];

endmodule

>>> hw/rtl/ret_cordic.sv
// ----------------------------------------------------------------------------
// Euler angle atan2 unit
// Vectoring CORDIC in degrees: half-turn fold, one iteration per stage, clamp.
// ----------------------------------------------------------------------------
module ret_cordic
    import ret_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [OPD_W-1:0]     y_in,
    input  logic signed [OPD_W-1:0]     x_in,
    output logic signed [ANG_OUT_W-1:0] ang
);

    logic signed [CRD_W-1:0] x_reg [0:STEPS];
    logic signed [CRD_W-1:0] y_reg [0:STEPS];
    logic signed [ANG_W-1:0] a_reg [0:STEPS];
    logic signed [CRD_W-1:0] x_ext, y_ext;
    logic signed [ANG_OUT_W-1:0] ang_reg;

    assign x_ext = CRD_W'(x_in);
    assign y_ext = CRD_W'(y_in);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (x_ext < 0) begin
                x_reg[0] <= -x_ext;
                y_reg[0] <= -y_ext;
                a_reg[0] <= (y_ext >= 0) ? HALF_TURN : -HALF_TURN;
            end else begin
                x_reg[0] <= x_ext;
                y_reg[0] <= y_ext;
                a_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_it
        logic signed [CRD_W-1:0] xs, ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    a_reg[i+1] <= a_reg[i] + atan_deg(i);
                end else if (y_reg[i] < 0) begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    a_reg[i+1] <= a_reg[i] - atan_deg(i);
                end else begin
                    x_reg[i+1] <= x_reg[i];
                    y_reg[i+1] <= y_reg[i];
                    a_reg[i+1] <= a_reg[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (a_reg[STEPS] > HALF_TURN) begin
                ang_reg <= ANG_OUT_W'(HALF_TURN);
            end else if (a_reg[STEPS] < -HALF_TURN) begin
                ang_reg <= ANG_OUT_W'(-HALF_TURN);
            end else begin
                ang_reg <= a_reg[STEPS][ANG_OUT_W-1:0];
            end
        end
    end

    assign ang = ang_reg;

endmodule

>>> hw/rtl/rotation_matrix_to_euler_angles.sv
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles (x-y-z)
// Q1.30 matrix elements in, angles in degrees (Q22) and a gimbal-lock flag out.
// ----------------------------------------------------------------------------
// channel | direction | payload
// s_      | in        | tdata: m00 m10 m20 m21 m22 m11 m12 (32 b each)
// m_      | out       | tdata: angle_x/y/z_deg (31 b each), tuser: is_singular
// cfg_    | in        | cfg_data: singular_threshold (31 b)
//
// A square stage, a sum stage, 32 root-digit stages, one select stage, then
// the CORDIC pipeline. One item per cycle while m_ is not stalled. All stages
// advance together; a stall at m_ holds the whole pipeline. aresetn clears
// valid bits and loads the threshold reset.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_euler_angles_macros.svh"

module rotation_matrix_to_euler_angles
    import ret_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [223:0]      s_tdata,   // m00, m10, m20, m21, m22, m11, m12
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [95:0]       m_tdata,   // angle_x_deg, angle_y_deg, angle_z_deg, pad
    output logic [0:0]        m_tuser,   // is_singular
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [THR_W-1:0]  cfg_data
);

    localparam int LAT = SQ_LAT + 1 + CORDIC_STEPS + 2;
    localparam int SGL = CORDIC_STEPS + 2;
    localparam logic signed [ANG_OUT_W-1:0] ANG_LIM = ANG_OUT_W'(HALF_TURN);

    logic                    pipe_en;
    logic [LAT-1:0]          vld_reg;
    logic [THR_W-1:0]        thr_reg;
    mat_t                    in_mat;
    mat_t                    dly_reg [0:SQ_LAT-1];
    logic [31:0]             sy;
    logic                    sing;
    logic signed [OPD_W-1:0] yy_reg, yx_reg, xy_reg, xx_reg, zy_reg, zx_reg;
    logic [SGL:0]            sgl_reg;
    logic signed [ANG_OUT_W-1:0] ang_x, ang_y, ang_z;
    logic signed [ANG_OUT_W-1:0] out_x;

    assign pipe_en   = !m_tvalid || m_tready;
    assign s_tready  = pipe_en;
    assign cfg_ready = 1'b1;
    assign in_mat    = {s_tdata[31:0], s_tdata[63:32], s_tdata[95:64], s_tdata[127:96],
                        s_tdata[159:128], s_tdata[191:160], s_tdata[223:192]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESH_RESET;
            vld_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                thr_reg <= cfg_data;
            end
            if (pipe_en) begin
                vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
            end
        end
    end

    ret_isqrt u_isqrt (
        .aclk (aclk),
        .en   (pipe_en),
        .m00  (in_mat.m00),
        .m10  (in_mat.m10),
        .sy   (sy)
    );

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            dly_reg[0] <= in_mat;
            for (int k = 1; k < SQ_LAT; k++) begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    assign sing = sy < {1'b0, thr_reg};

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            yy_reg <= -OPD_W'(dly_reg[SQ_LAT-1].m20);
            yx_reg <= OPD_W'({1'b0, sy});
            if (sing) begin
                xy_reg <= -OPD_W'(dly_reg[SQ_LAT-1].m12);
                xx_reg <= OPD_W'(dly_reg[SQ_LAT-1].m11);
                zy_reg <= '0;
                zx_reg <= '0;
            end else begin
                xy_reg <= OPD_W'(dly_reg[SQ_LAT-1].m21);
                xx_reg <= OPD_W'(dly_reg[SQ_LAT-1].m22);
                zy_reg <= OPD_W'(dly_reg[SQ_LAT-1].m10);
                zx_reg <= OPD_W'(dly_reg[SQ_LAT-1].m00);
            end
            sgl_reg <= {sgl_reg[SGL-1:0], sing};
        end
    end

    ret_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_x (
        .aclk (aclk), .en (pipe_en), .y_in (xy_reg), .x_in (xx_reg), .ang (ang_x)
    );
    ret_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_y (
        .aclk (aclk), .en (pipe_en), .y_in (yy_reg), .x_in (yx_reg), .ang (ang_y)
    );
    ret_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_z (
        .aclk (aclk), .en (pipe_en), .y_in (zy_reg), .x_in (zx_reg), .ang (ang_z)
    );

    assign m_tvalid   = vld_reg[LAT-1];
    assign m_tdata    = {3'b000, ang_z, ang_y, ang_x};
    assign m_tuser[0] = sgl_reg[SGL];
    assign out_x      = m_tdata[ANG_OUT_W-1:0];

    `RET_ASSERT(a_sing_z_zero, m_tvalid && m_tuser[0] |-> m_tdata[92:62] == '0, "z nonzero")
    `RET_ASSERT(a_x_range, m_tvalid |-> out_x <= ANG_LIM && out_x >= -ANG_LIM, "x past limit")
    `RET_ASSERT(a_stall_hold, !pipe_en |=> $stable(vld_reg), "pipeline moved during stall")
    `RET_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "item out after reset")

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles testbench
// Drives Q1.30 matrix items into the block, predicts each angle triple and
// the gimbal-lock flag with a bit-exact integer root and degree CORDIC, and
// checks every result in order. Random gaps on both sides; the threshold is
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import ret_pkg::*;

    localparam int  N_STEPS   = 24;
    localparam int  DRAIN_CYC = 80;
    localparam int  MAX_CYC   = 2000000;
    localparam logic [THR_W-1:0] THR_MAX_Q = 31'h7FFFFFFF;
    localparam logic [THR_W-1:0] THR_ONE   = 31'd1073741824;

    typedef struct {
        logic signed [ANG_OUT_W-1:0] ax;
        logic signed [ANG_OUT_W-1:0] ay;
        logic signed [ANG_OUT_W-1:0] az;
        logic                        sing;
    } angles_t;

    class euler_scoreboard;
        angles_t                 pending[$];
        logic [THR_W-1:0]        threshold;
        int                      n_err;
        int                      n_ok;
        int                      n_sing;
        longint                  atan_tbl[32];

        function new();
            longint t[32] = '{188743680, 111421900, 58872272, 29884485, 15000234,
                7507429, 3754631, 1877430, 938729, 469366, 234683, 117342, 58671,
                29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14,
                7, 4, 2, 1, 0, 0, 0};
            atan_tbl = t;
            threshold = THRESH_RESET;
            n_err = 0;
            n_ok = 0;
            n_sing = 0;
        endfunction

        function longint unsigned int_root(longint unsigned n);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint atan2_deg(longint y, longint x);
            longint a;
            longint xs;
            longint ys;
            a = 0;
            if (x < 0) begin
                a = (y >= 0) ? 754974720 : -754974720;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < N_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys;
                    y = y - xs;
                    a = a + atan_tbl[i];
                end else if (y < 0) begin
                    x = x - ys;
                    y = y + xs;
                    a = a - atan_tbl[i];
                end
            end
            if (a > 754974720) a = 754974720;
            if (a < -754974720) a = -754974720;
            return a;
        endfunction

        function void note_matrix(logic [223:0] d);
            longint m[7];
            longint unsigned sa;
            longint unsigned sb;
            longint unsigned sy;
            angles_t e;
            for (int k = 0; k < 7; k++) m[k] = longint'($signed(d[32*k +: 32]));
            sa = (m[0] < 0) ? -m[0] : m[0];
            sb = (m[1] < 0) ? -m[1] : m[1];
            sy = int_root(sa * sa + sb * sb);
            e.sing = (sy < threshold);
            e.ay = ANG_OUT_W'(atan2_deg(-m[2], longint'(sy)));
            if (!e.sing) begin
                e.ax = ANG_OUT_W'(atan2_deg(m[3], m[4]));
                e.az = ANG_OUT_W'(atan2_deg(m[1], m[0]));
            end else begin
                e.ax = ANG_OUT_W'(atan2_deg(-m[6], m[5]));
                e.az = '0;
            end
            pending = {pending, e};
        endfunction

        function void check_angles(logic [95:0] d, logic [0:0] u);
            angles_t e;
            if (pending.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result item: %h %b", d, u);
                return;
            end
            e = pending.pop_front();
            if (d[30:0] !== e.ax || d[61:31] !== e.ay || d[92:62] !== e.az
                    || u[0] !== e.sing) begin
                n_err++;
                if (n_err <= 10)
                    $display("mismatch: exp x=%0d y=%0d z=%0d s=%0b got x=%0d y=%0d z=%0d s=%0b",
                        e.ax, e.ay, e.az, e.sing, $signed(d[30:0]), $signed(d[61:31]),
                        $signed(d[92:62]), u[0]);
            end else begin
                n_ok++;
                if (e.sing) n_sing++;
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [223:0]      s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [95:0]       m_tdata;
    logic [0:0]        m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [THR_W-1:0]  cfg_data = '0;

    euler_scoreboard sb = new();
    bit      no_idle = 1'b0;
    longint  cycles = 0;
    int      n_sent = 0;
    int      n_cfg = 0;

    rotation_matrix_to_euler_angles #(.CORDIC_STEPS(N_STEPS)) dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_matrix(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_angles(m_tdata, m_tuser);
    end

    initial begin : result_side
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_matrix(logic [223:0] d);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.threshold = v;
        n_cfg++;
    endtask

    function automatic logic [223:0] pack7(int a0, int a1, int a2, int a3, int a4,
                                           int a5, int a6);
        return {a6, a5, a4, a3, a2, a1, a0};
    endfunction

    function automatic int elem(int sel);
        case (sel)
            0: return int'($urandom_range(0, 32'h80000000)) - 32'sh40000000;
            1: return int'($urandom());
            2: return int'($urandom_range(0, 4000)) - 2000;
            default: begin
                case ($urandom_range(0, 4))
                    0: return 0;
                    1: return 32'sh40000000;
                    2: return -32'sh40000000;
                    3: return 32'sh7FFFFFFF;
                    default: return 32'sh80000000;
                endcase
            end
        endcase
    endfunction

    function automatic logic [223:0] random_matrix();
        int k;
        int v[7];
        int c;
        c = $urandom_range(0, 9);
        for (k = 0; k < 7; k++) begin
            if (c < 5) v[k] = elem(0);
            else if (c < 7) v[k] = elem(1);
            else if (c < 8) v[k] = elem($urandom_range(0, 3));
            else v[k] = (k < 2) ? elem(2) : elem($urandom_range(0, 1));
        end
        return pack7(v[0], v[1], v[2], v[3], v[4], v[5], v[6]);
    endfunction

    task automatic random_run(int n);
        for (int i = 0; i < n; i++) send_matrix(random_matrix());
    endtask

    localparam int P1 = 32'sh40000000;
    localparam int N1 = -32'sh40000000;
    localparam int PM = 32'sh7FFFFFFF;
    localparam int NM = 32'sh80000000;

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_matrix(pack7(P1, 0, 0, 0, P1, P1, 0));
        send_matrix(pack7(0, 0, 0, 0, 0, 0, 0));
        send_matrix(pack7(N1, 0, 0, 0, N1, N1, 0));
        send_matrix(pack7(0, P1, 0, P1, 0, 0, P1));
        send_matrix(pack7(0, N1, 0, N1, 0, 0, N1));
        send_matrix(pack7(0, 0, P1, 0, 0, P1, P1));
        send_matrix(pack7(0, 0, N1, 0, 0, N1, N1));
        send_matrix(pack7(0, 0, P1, 0, 0, N1, 0));
        send_matrix(pack7(0, 0, 0, 0, 0, 0, P1));
        send_matrix(pack7(PM, PM, PM, PM, PM, PM, PM));
        send_matrix(pack7(NM, NM, NM, NM, NM, NM, NM));
        send_matrix(pack7(NM, PM, NM, PM, NM, PM, NM));
        send_matrix(pack7(PM, NM, PM, NM, PM, NM, PM));
        send_matrix(pack7(1073, 0, 5, 7, -9, 3, -3));
        send_matrix(pack7(1074, 0, -5, -7, 9, -3, 3));
        send_matrix(pack7(759, 759, P1, 1, 1, -1, -1));
        send_matrix(pack7(-1, -1, -1, -1, -1, -1, -1));
        send_matrix(pack7(1, 1, 1, 1, 1, 1, 1));
        send_matrix(pack7(759250125, 759250125, 0, 759250125, -759250125, 0, 0));
        send_matrix(pack7(-759250125, 759250125, 0, -759250125, -759250125, 0, 0));
        random_run(380);
        drain();

        write_threshold('0);
        random_run(250);
        no_idle = 1'b1;
        random_run(50);
        no_idle = 1'b0;
        drain();

        write_threshold(THR_MAX_Q);
        random_run(200);
        drain();

        write_threshold(THR_ONE);
        send_matrix(pack7(P1, 0, 0, 0, P1, P1, 0));
        send_matrix(pack7(P1 - 1, 0, 0, 0, P1, P1, 0));
        random_run(200);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            write_threshold(THR_W'($urandom_range(0, 5000)));
            random_run(150);
            drain();
        end
        write_threshold(THRESH_RESET);
        no_idle = 1'b1;
        random_run(40);
        no_idle = 1'b0;
        drain();

        $display("sent %0d matrices, %0d results ok (%0d gimbal-locked), %0d errors",
            n_sent, sb.n_ok, sb.n_sing, sb.n_err);
        $display("threshold rewritten %0d times incl. 0 and all-ones", n_cfg);
        if (sb.n_err == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
